// ===== rtl/core/cfsbs_pkg.sv =====
// ----------------------------------------------------------------------------
// cfsbs_pkg
// Shared widths, codes, frame layout constants and types for the CAN frame
// serializer with bit stuffing.
// ----------------------------------------------------------------------------
package cfsbs_pkg;

    // Field widths.
    localparam int ID_W   = 11;
    localparam int LEN_W  = 4;
    localparam int DATA_W = 64;
    localparam int CRC_W  = 15;
    localparam int POS_W  = 7;
    localparam int RUN_W  = 3;

    // Parameter defaults.
    localparam int STUFF_RUN_DEF      = 5;
    localparam int MAX_DATA_BYTES_DEF = 8;

    // Command codes.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Bus levels.
    localparam logic LVL_DOMINANT  = 1'b0;
    localparam logic LVL_RECESSIVE = 1'b1;

    // CRC-15 generator polynomial.
    localparam logic [CRC_W-1:0] CRC_POLY = 15'h4599;

    // Frame layout, in unstuffed bit positions.
    localparam logic [POS_W-1:0] POS_ID_LAST    = 7'd11;
    localparam logic [POS_W-1:0] POS_CTRL_LAST  = 7'd14;
    localparam logic [POS_W-1:0] POS_DLC_LAST   = 7'd18;
    localparam logic [POS_W-1:0] POS_DATA_FIRST = 7'd19;
    localparam logic [POS_W-1:0] CRC_LAST_OFS   = 7'd14;
    localparam logic [POS_W-1:0] ACK_SLOT_OFS   = 7'd16;
    localparam logic [POS_W-1:0] STUFF_END_BASE = 7'd34;
    localparam logic [POS_W-1:0] TRAILER_BITS   = 7'd13;

    // Saturation limit of the stuffing run counter.
    localparam logic [RUN_W-1:0] RUN_MAX = 3'd7;

    // Unstuffed frame bit and whether it feeds the CRC.
    typedef struct packed {
        logic level;
        logic crc_in;
    } t_bit_info;

endpackage

// ===== rtl/core/cfsbs_ifs.sv =====
// ----------------------------------------------------------------------------
// cfsbs_ifs
// Valid/ready channels for the load/tick beats and for the transmitted bits.
// ----------------------------------------------------------------------------

// Input channel: one load or tick beat.
interface cfsbs_in_if;
    logic                         valid;
    logic                         ready;
    logic                         command;
    logic [cfsbs_pkg::ID_W-1:0]   frame_id;
    logic [cfsbs_pkg::LEN_W-1:0]  data_length;
    logic [cfsbs_pkg::DATA_W-1:0] payload;

    modport source (output valid, command, frame_id, data_length, payload,
                    input ready);
    modport sink   (input valid, command, frame_id, data_length, payload,
                    output ready);
endinterface

// Output channel: one bus bit beat.
interface cfsbs_out_if;
    logic valid;
    logic ready;
    logic tx_bit;
    logic is_stuff;
    logic frame_last;

    modport source (output valid, tx_bit, is_stuff, frame_last, input ready);
    modport sink   (input valid, tx_bit, is_stuff, frame_last, output ready);
endinterface

// ===== rtl/core/cfsbs_bit_source.sv =====
// ----------------------------------------------------------------------------
// cfsbs_bit_source
// Selects the unstuffed frame bit for a bit position from the latched frame
// fields and flags the bits that are covered by the CRC.
// ----------------------------------------------------------------------------
module cfsbs_bit_source (
    input  logic [cfsbs_pkg::POS_W-1:0]  i_pos,
    input  logic [cfsbs_pkg::ID_W-1:0]   i_id,
    input  logic [cfsbs_pkg::LEN_W-1:0]  i_len,
    input  logic [cfsbs_pkg::DATA_W-1:0] i_data,
    input  logic [cfsbs_pkg::CRC_W-1:0]  i_crc,
    output cfsbs_pkg::t_bit_info         o_info
);
    import cfsbs_pkg::*;

    logic [POS_W-1:0] nbits;
    logic [POS_W-1:0] data_end;
    logic [POS_W-1:0] id_ofs;
    logic [POS_W-1:0] dlc_ofs;
    logic [POS_W-1:0] data_ofs;
    logic [POS_W-1:0] crc_ofs;

    // Offsets into each field, counted from its LSB.
    assign nbits    = {i_len, 3'b000};
    assign data_end = POS_DATA_FIRST + nbits;
    assign id_ofs   = POS_ID_LAST - i_pos;
    assign dlc_ofs  = POS_DLC_LAST - i_pos;
    assign data_ofs = nbits + POS_DLC_LAST - i_pos;
    assign crc_ofs  = data_end + CRC_LAST_OFS - i_pos;

    // Field selection in frame order.
    always_comb begin
        o_info.level  = LVL_RECESSIVE;
        o_info.crc_in = 1'b0;
        priority if (i_pos == '0) begin
            o_info.level  = LVL_DOMINANT;
            o_info.crc_in = 1'b1;
        end else if (i_pos <= POS_ID_LAST) begin
            o_info.level  = i_id[id_ofs[3:0]];
            o_info.crc_in = 1'b1;
        end else if (i_pos <= POS_CTRL_LAST) begin
            o_info.level  = LVL_DOMINANT;
            o_info.crc_in = 1'b1;
        end else if (i_pos <= POS_DLC_LAST) begin
            o_info.level  = i_len[dlc_ofs[1:0]];
            o_info.crc_in = 1'b1;
        end else if (i_pos < data_end) begin
            o_info.level  = i_data[data_ofs[5:0]];
            o_info.crc_in = 1'b1;
        end else if (i_pos <= data_end + CRC_LAST_OFS) begin
            o_info.level  = i_crc[crc_ofs[3:0]];
        end else if (i_pos == data_end + ACK_SLOT_OFS) begin
            o_info.level  = LVL_DOMINANT;
        end else begin
            o_info.level  = LVL_RECESSIVE;
        end
    end

endmodule

// ===== rtl/core/can_frame_serializer_bit_stuffing.sv =====
// ----------------------------------------------------------------------------
// can_frame_serializer_bit_stuffing
// Standard-format CAN data frame transmitter with CRC-15 and bit stuffing.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries load and tick beats. A load beat latches the
//   identifier, the byte count (saturated at MAX_DATA_BYTES) and the payload,
//   and abandons any frame in flight; it produces no output beat. Each tick
//   beat produces exactly one output beat with the bus level of that bit
//   time, a stuff flag and a flag on the final intermission bit. Ticks while
//   idle give a recessive bit.
//   Latency: the output beat of a tick is valid in the cycle after the tick
//   is accepted. Throughput: one beat per cycle while the receiver is ready;
//   the state update and the bit selection are combinational, and the output
//   register is the only stage.
//   The input is ready whenever the output register is empty or is being
//   drained in the same cycle, so a stalled receiver holds its bit and stalls
//   the input after one beat.
//   Reset (synchronous, active low) returns the block to idle with the
//   previous level recessive and the output register empty.
// ----------------------------------------------------------------------------
module can_frame_serializer_bit_stuffing #(
    parameter int STUFF_RUN      = cfsbs_pkg::STUFF_RUN_DEF,
    parameter int MAX_DATA_BYTES = cfsbs_pkg::MAX_DATA_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cfsbs_in_if.sink    i_in,
    cfsbs_out_if.source o_out
);
    import cfsbs_pkg::*;

    localparam logic [RUN_W-1:0] RUN_LIMIT = RUN_W'(STUFF_RUN);
    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_DATA_BYTES);

    // Frame state.
    logic              r_busy, n_busy;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [ID_W-1:0]   r_id, n_id;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [DATA_W-1:0] r_data, n_data;
    logic [CRC_W-1:0]  r_crc, n_crc;
    logic [RUN_W-1:0]  r_run, n_run;
    logic              r_prev, n_prev;

    // Output register.
    logic r_out_valid, n_out_valid;
    logic r_tx_bit, n_tx_bit;
    logic r_is_stuff, n_is_stuff;
    logic r_frame_last, n_frame_last;

    logic             accept;
    logic [LEN_W-1:0] load_len;
    logic [POS_W-1:0] stuff_end;
    logic [POS_W-1:0] total;
    logic             stuff_now;
    logic             feedback;
    t_bit_info        info;

    // Handshake: the output register parts the two sides.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    assign o_out.valid      = r_out_valid;
    assign o_out.tx_bit     = r_tx_bit;
    assign o_out.is_stuff   = r_is_stuff;
    assign o_out.frame_last = r_frame_last;

    // Frame geometry for the latched length.
    assign load_len  = (i_in.data_length > LEN_LIMIT) ? LEN_LIMIT : i_in.data_length;
    assign stuff_end = STUFF_END_BASE + {r_len, 3'b000};
    assign total     = stuff_end + TRAILER_BITS;
    assign stuff_now = (r_pos != '0) && (r_pos <= stuff_end) && (r_run >= RUN_LIMIT);
    assign feedback  = info.level ^ r_crc[CRC_W-1];

    cfsbs_bit_source u_bit_source (
        .i_pos  (r_pos),
        .i_id   (r_id),
        .i_len  (r_len),
        .i_data (r_data),
        .i_crc  (r_crc),
        .o_info (info)
    );

    // Next state and next output beat.
    always_comb begin
        n_busy       = r_busy;
        n_pos        = r_pos;
        n_id         = r_id;
        n_len        = r_len;
        n_data       = r_data;
        n_crc        = r_crc;
        n_run        = r_run;
        n_prev       = r_prev;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_tx_bit     = r_tx_bit;
        n_is_stuff   = r_is_stuff;
        n_frame_last = r_frame_last;
        if (accept) begin
            unique case (i_in.command)
                CMD_LOAD: begin
                    n_busy = 1'b1;
                    n_pos  = '0;
                    n_id   = i_in.frame_id;
                    n_len  = load_len;
                    n_data = i_in.payload;
                    n_crc  = '0;
                    n_run  = '0;
                    n_prev = LVL_RECESSIVE;
                end
                CMD_TICK: begin
                    n_out_valid  = 1'b1;
                    n_tx_bit     = LVL_RECESSIVE;
                    n_is_stuff   = 1'b0;
                    n_frame_last = 1'b0;
                    if (r_busy && stuff_now) begin
                        // Complement the run; the frame position holds.
                        n_tx_bit   = !r_prev;
                        n_is_stuff = 1'b1;
                        n_prev     = !r_prev;
                        n_run      = RUN_W'(1);
                    end else if (r_busy) begin
                        n_tx_bit = info.level;
                        if (info.crc_in) begin
                            n_crc = {r_crc[CRC_W-2:0], 1'b0} ^ (feedback ? CRC_POLY : '0);
                        end
                        if (r_pos < stuff_end) begin
                            if (info.level == r_prev) begin
                                n_run = (r_run < RUN_MAX) ? r_run + RUN_W'(1) : r_run;
                            end else begin
                                n_run = RUN_W'(1);
                            end
                            n_prev = info.level;
                        end
                        if (r_pos + POS_W'(1) >= total) begin
                            n_frame_last = 1'b1;
                            n_busy       = 1'b0;
                            n_pos        = '0;
                            n_run        = '0;
                            n_prev       = LVL_RECESSIVE;
                        end else begin
                            n_pos = r_pos + POS_W'(1);
                        end
                    end
                end
                default: begin
                    n_out_valid = r_out_valid && !o_out.ready;
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pos       <= '0;
            r_run       <= '0;
            r_prev      <= LVL_RECESSIVE;
            r_crc       <= '0;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_pos       <= n_pos;
            r_run       <= n_run;
            r_prev      <= n_prev;
            r_crc       <= n_crc;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_id         <= n_id;
        r_data       <= n_data;
        r_tx_bit     <= n_tx_bit;
        r_is_stuff   <= n_is_stuff;
        r_frame_last <= n_frame_last;
    end

endmodule

// ===== bench/can_frame_serializer_bit_stuffing_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_frame_serializer_bit_stuffing_tb
// Self-checking bench for the CAN data frame serializer. A table of directed
// loads and ticks covers the field extremes, length saturation, abandoned
// frames and idle ticks. Random frames with randomly stalled handshakes
// follow. Every output beat is compared with an in-bench model of the frame
// layout, the CRC-15 and the bit stuffing, or with a bit from the table.
// ----------------------------------------------------------------------------
module can_frame_serializer_bit_stuffing_tb;
    import cfsbs_pkg::*;

    localparam int RANDOM_BEATS   = 500;
    localparam int RUN_TO_END     = -1;
    localparam int DRAIN_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 400;

    // One transmitted bit as seen on the output channel.
    typedef struct packed {
        logic tx_bit;
        logic is_stuff;
        logic frame_last;
    } t_bus_bit;

    // One row of directed stimulus. A tick row repeats reps times, or runs
    // the current frame to its end when reps is RUN_TO_END.
    typedef struct packed {
        logic              cmd;
        logic [ID_W-1:0]   id;
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] data;
        int                reps;
        logic              has_exp;
        t_bus_bit          exp;
    } t_stim_row;

    localparam t_bus_bit IDLE_BIT = '{LVL_RECESSIVE, 1'b0, 1'b0};
    localparam t_bus_bit SOF_BIT  = '{LVL_DOMINANT, 1'b0, 1'b0};

    logic i_clk = 1'b0;
    logic i_rst_n;

    cfsbs_in_if  in_if ();
    cfsbs_out_if out_if ();

    can_frame_serializer_bit_stuffing i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #10 i_clk = ~i_clk;

    // Transmitter state of the bench's own frame model.
    logic              tx_busy;
    logic [POS_W-1:0]  pos_q;
    logic [ID_W-1:0]   id_q;
    logic [LEN_W-1:0]  len_q;
    logic [DATA_W-1:0] data_q;
    logic [CRC_W-1:0]  crc_q;
    logic [RUN_W-1:0]  run_q;
    logic              prev_level;

    t_bus_bit  expected_bits[$];
    t_stim_row dir_rows[$];

    int mismatches   = 0;
    int beats_sent   = 0;
    int frames_done  = 0;
    int stuff_bits   = 0;
    int sat_loads    = 0;
    int idle_cycles  = 0;
    bit src_burst    = 1'b0;

    // Latch a new frame; a frame in flight is dropped.
    function automatic void frame_load(input logic [ID_W-1:0] id,
                                       input logic [LEN_W-1:0] len,
                                       input logic [DATA_W-1:0] data);
        tx_busy    = 1'b1;
        pos_q      = '0;
        id_q       = id;
        len_q      = (len > MAX_DATA_BYTES_DEF) ? LEN_W'(MAX_DATA_BYTES_DEF) : len;
        data_q     = data;
        crc_q      = '0;
        run_q      = '0;
        prev_level = LVL_RECESSIVE;
        if (len > MAX_DATA_BYTES_DEF) sat_loads++;
    endfunction

    // Unstuffed level at frame position p, and whether it feeds the CRC.
    function automatic logic frame_level(input int p, output logic feeds_crc);
        int nbits;
        int data_end;
        nbits     = 8 * int'(len_q);
        data_end  = int'(POS_DATA_FIRST) + nbits;
        feeds_crc = 1'b1;
        if (p == 0) return LVL_DOMINANT;
        if (p <= int'(POS_ID_LAST)) return id_q[int'(POS_ID_LAST) - p];
        if (p <= int'(POS_CTRL_LAST)) return LVL_DOMINANT;
        if (p <= int'(POS_DLC_LAST)) return len_q[int'(POS_DLC_LAST) - p];
        if (p < data_end) return data_q[nbits - 1 - (p - int'(POS_DATA_FIRST))];
        feeds_crc = 1'b0;
        if (p < data_end + CRC_W) return crc_q[int'(CRC_LAST_OFS) - (p - data_end)];
        if (p == data_end + int'(ACK_SLOT_OFS)) return LVL_DOMINANT;
        return LVL_RECESSIVE;
    endfunction

    // Advance the model by one bit time and return the bit it puts on the bus.
    function automatic t_bus_bit bus_bit_next();
        t_bus_bit r;
        int       stuff_end;
        int       total;
        logic     lvl;
        logic     feeds_crc;
        logic     fb;
        r = IDLE_BIT;
        if (!tx_busy) return r;
        stuff_end = int'(STUFF_END_BASE) + 8 * int'(len_q);
        total     = stuff_end + int'(TRAILER_BITS);

        // A full run of equal bits forces a complementary stuff bit.
        if (pos_q > 0 && int'(pos_q) <= stuff_end && int'(run_q) >= STUFF_RUN_DEF) begin
            r.tx_bit   = ~prev_level;
            r.is_stuff = 1'b1;
            prev_level = r.tx_bit;
            run_q      = RUN_W'(1);
            stuff_bits++;
            return r;
        end

        lvl      = frame_level(int'(pos_q), feeds_crc);
        r.tx_bit = lvl;

        if (feeds_crc) begin
            fb    = lvl ^ crc_q[CRC_W-1];
            crc_q = {crc_q[CRC_W-2:0], 1'b0};
            if (fb) crc_q = crc_q ^ CRC_POLY;
        end

        // Track the run length only inside the stuffed region.
        if (int'(pos_q) < stuff_end) begin
            if (lvl == prev_level) begin
                if (run_q < RUN_MAX) run_q = run_q + 1'b1;
            end else begin
                run_q = RUN_W'(1);
            end
            prev_level = lvl;
        end

        if (int'(pos_q) + 1 >= total) begin
            r.frame_last = 1'b1;
            tx_busy      = 1'b0;
            pos_q        = '0;
            run_q        = '0;
            prev_level   = LVL_RECESSIVE;
            frames_done++;
        end else begin
            pos_q = pos_q + 1'b1;
        end
        return r;
    endfunction

    // Drive one input beat after a random gap, then predict once it is taken.
    task automatic send_beat(input logic cmd, input logic [ID_W-1:0] id,
                             input logic [LEN_W-1:0] len, input logic [DATA_W-1:0] data,
                             input logic use_typed, input t_bus_bit typed);
        int       gap;
        t_bus_bit pred;
        gap = src_burst ? 0 : $urandom_range(0, 16);
        if ($urandom_range(0, 31) == 0) src_burst = ~src_burst;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.command     <= cmd;
        in_if.frame_id    <= id;
        in_if.data_length <= len;
        in_if.payload     <= data;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        beats_sent++;
        if (cmd == CMD_LOAD) begin
            frame_load(id, len, data);
        end else begin
            pred = bus_bit_next();
            expected_bits.push_back(use_typed ? typed : pred);
        end
    endtask

    // A tick with don't-care fields filled with noise.
    task automatic send_tick();
        send_beat(CMD_TICK, ID_W'($urandom), LEN_W'($urandom), {$urandom, $urandom},
                  1'b0, IDLE_BIT);
    endtask

    function automatic void add_row(input logic cmd, input logic [ID_W-1:0] id,
                                    input logic [LEN_W-1:0] len,
                                    input logic [DATA_W-1:0] data, input int reps,
                                    input logic has_exp, input t_bus_bit exp);
        dir_rows.push_back('{cmd, id, len, data, reps, has_exp, exp});
    endfunction

    // Output side: random stalls, and every beat checked against the model.
    initial begin : bus_monitor
        t_bus_bit want;
        int       stall;
        bit       sink_burst;
        sink_burst = 1'b0;
        out_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = sink_burst ? 0 : $urandom_range(0, 16);
            if ($urandom_range(0, 31) == 0) sink_burst = ~sink_burst;
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (out_if.valid !== 1'b1);
            if (expected_bits.size() == 0) begin
                $error("bus bit with no tick waiting: tx_bit %b is_stuff %b frame_last %b",
                       out_if.tx_bit, out_if.is_stuff, out_if.frame_last);
                mismatches++;
            end else begin
                want = expected_bits.pop_front();
                if (out_if.tx_bit !== want.tx_bit) begin
                    $error("tx_bit: expected %b, actual %b", want.tx_bit, out_if.tx_bit);
                    mismatches++;
                end
                if (out_if.is_stuff !== want.is_stuff) begin
                    $error("is_stuff: expected %b, actual %b", want.is_stuff, out_if.is_stuff);
                    mismatches++;
                end
                if (out_if.frame_last !== want.frame_last) begin
                    $error("frame_last: expected %b, actual %b",
                           want.frame_last, out_if.frame_last);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a beat.
    always @(posedge i_clk) begin
        if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
            (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no beat for %0d cycles, %0d bits outstanding",
                     idle_cycles, expected_bits.size());
            $display("can_frame_serializer_bit_stuffing verification failed");
            $finish;
        end
    end

    // Stimulus: directed table, random frames, then drain and report.
    initial begin : stimulus
        t_stim_row row;
        int        pick;
        int        ticks;
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] data;

        in_if.valid       <= 1'b0;
        in_if.command     <= CMD_TICK;
        in_if.frame_id    <= '0;
        in_if.data_length <= '0;
        in_if.payload     <= '0;
        i_rst_n           <= 1'b0;
        tx_busy    = 1'b0;
        pos_q      = '0;
        id_q       = '0;
        len_q      = '0;
        data_q     = '0;
        crc_q      = '0;
        run_q      = '0;
        prev_level = LVL_RECESSIVE;

        // Idle ticks after reset give a recessive bus.
        add_row(CMD_TICK, '0, '0, '0, 1, 1'b1, IDLE_BIT);
        add_row(CMD_TICK, '0, '0, '0, 3, 1'b0, IDLE_BIT);
        // All-zero frame: long dominant runs, heavy stuffing.
        add_row(CMD_LOAD, 11'h000, 4'd0, 64'h0, 0, 1'b0, IDLE_BIT);
        add_row(CMD_TICK, '0, '0, '0, 1, 1'b1, SOF_BIT);
        add_row(CMD_TICK, '0, '0, '0, RUN_TO_END, 1'b0, IDLE_BIT);
        // All-ones identifier and full payload.
        add_row(CMD_LOAD, 11'h7FF, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 0, 1'b0, IDLE_BIT);
        add_row(CMD_TICK, '0, '0, '0, RUN_TO_END, 1'b0, IDLE_BIT);
        // Alternating bits: no stuffing in identifier or data.
        add_row(CMD_LOAD, 11'h555, 4'd8, 64'hAAAA_AAAA_AAAA_AAAA, 0, 1'b0, IDLE_BIT);
        add_row(CMD_TICK, '0, '0, '0, RUN_TO_END, 1'b0, IDLE_BIT);
        // Lengths above eight saturate, including the largest code.
        add_row(CMD_LOAD, 11'h2AA, 4'd15, 64'h0123_4567_89AB_CDEF, 0, 1'b0, IDLE_BIT);
        add_row(CMD_TICK, '0, '0, '0, RUN_TO_END, 1'b0, IDLE_BIT);
        add_row(CMD_LOAD, 11'h400, 4'd9, 64'h00FF_00FF_00FF_00FF, 0, 1'b0, IDLE_BIT);
        add_row(CMD_TICK, '0, '0, '0, RUN_TO_END, 1'b0, IDLE_BIT);
        // Zero length ignores the payload.
        add_row(CMD_LOAD, 11'h001, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 0, 1'b0, IDLE_BIT);
        add_row(CMD_TICK, '0, '0, '0, RUN_TO_END, 1'b0, IDLE_BIT);
        add_row(CMD_LOAD, 11'h7C0, 4'd1, 64'h0000_0000_0000_001F, 0, 1'b0, IDLE_BIT);
        add_row(CMD_TICK, '0, '0, '0, RUN_TO_END, 1'b0, IDLE_BIT);
        // A load in mid-frame abandons the frame in flight.
        add_row(CMD_LOAD, 11'h3FF, 4'd4, 64'hDEAD_BEEF_C0DE_F00D, 0, 1'b0, IDLE_BIT);
        add_row(CMD_TICK, '0, '0, '0, 25, 1'b0, IDLE_BIT);
        add_row(CMD_LOAD, 11'h0F0, 4'd2, 64'h0000_0000_0000_F00F, 0, 1'b0, IDLE_BIT);
        add_row(CMD_TICK, '0, '0, '0, RUN_TO_END, 1'b0, IDLE_BIT);
        // Back-to-back loads: only the second one is sent.
        add_row(CMD_LOAD, 11'h123, 4'd3, 64'h0000_0000_00AB_CDEF, 0, 1'b0, IDLE_BIT);
        add_row(CMD_LOAD, 11'h654, 4'd5, 64'h0000_0012_3456_789A, 0, 1'b0, IDLE_BIT);
        add_row(CMD_TICK, '0, '0, '0, RUN_TO_END, 1'b0, IDLE_BIT);
        add_row(CMD_TICK, '0, '0, '0, 1, 1'b1, IDLE_BIT);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.cmd == CMD_LOAD) begin
                send_beat(CMD_LOAD, row.id, row.len, row.data, 1'b0, IDLE_BIT);
            end else if (row.reps == RUN_TO_END) begin
                do send_tick(); while (tx_busy);
            end else begin
                repeat (row.reps)
                    send_beat(CMD_TICK, row.id, row.len, row.data, row.has_exp, row.exp);
            end
        end

        // Random part: mostly whole frames, some abandoned ones and stray ticks.
        beats_sent = 0;
        while (beats_sent < RANDOM_BEATS) begin
            pick = $urandom_range(0, 99);
            if (pick < 85) begin
                len = ($urandom_range(0, 3) == 0) ? LEN_W'($urandom_range(0, 15))
                                                  : LEN_W'($urandom_range(0, 8));
                case ($urandom_range(0, 7))
                    0:       data = '0;
                    1:       data = '1;
                    2:       data = {$urandom, $urandom} & {$urandom, $urandom};
                    3:       data = {$urandom, $urandom} | {$urandom, $urandom};
                    default: data = {$urandom, $urandom};
                endcase
                send_beat(CMD_LOAD, ID_W'($urandom), len, data, 1'b0, IDLE_BIT);
                if (pick < 70) begin
                    do send_tick(); while (tx_busy);
                end else begin
                    ticks = $urandom_range(0, 60);
                    repeat (ticks) send_tick();
                end
            end else begin
                ticks = $urandom_range(1, 6);
                repeat (ticks) send_tick();
            end
        end
        in_if.valid <= 1'b0;

        while (expected_bits.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d complete frames with %0d stuff bits checked,",
                 frames_done, stuff_bits);
        $display("%0d over-length loads, plus idle ticks and abandoned frames.", sat_loads);
        if (mismatches == 0) begin
            $display("can_frame_serializer_bit_stuffing verification clean");
        end else begin
            $display("can_frame_serializer_bit_stuffing verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/cfsbs_pkg.sv
rtl/core/cfsbs_ifs.sv
rtl/core/cfsbs_bit_source.sv
rtl/core/can_frame_serializer_bit_stuffing.sv
bench/can_frame_serializer_bit_stuffing_tb.sv
